/* design/cuckoo_hash_anti_join_filter_defines.svh */
// ----------------------------------------------------------------------------
// Cuckoo hash anti-join filter: assertion macros
// Shared assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef CUCKOO_HASH_ANTI_JOIN_FILTER_DEFINES_SVH
`define CUCKOO_HASH_ANTI_JOIN_FILTER_DEFINES_SVH

// Same-cycle implication.
`define CHAF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHAF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/chaf_pkg.sv */
// ----------------------------------------------------------------------------
// Cuckoo hash anti-join filter package
// Shared constants, types and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package chaf_pkg;

  localparam int TABLE_HALF_DEF    = 1024;
  localparam int MAX_KEY_WORDS_DEF = 3;
  // Number of key words the datapath carries: min(3, MAX_KEY_WORDS).
  localparam int KEY_CAP = (MAX_KEY_WORDS_DEF < 3) ? MAX_KEY_WORDS_DEF : 3;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_AGGREGATED = 3'd1,
    ST_DROPPED    = 3'd2,
    ST_PASS       = 3'd3,
    ST_FILTERED   = 3'd4
  } status_t;

  typedef struct packed {
    logic       start;
    logic [1:0] nwords;
  } hash_req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] w2;
    logic [31:0] w1;
    logic [31:0] w0;
    logic [31:0] cnt;
  } entry_t;

endpackage
`default_nettype wire

/* design/chaf_if.sv */
// ----------------------------------------------------------------------------
// Cuckoo hash anti-join filter channels
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface chaf_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] key_word0;
  logic [31:0] key_word1;
  logic [31:0] key_word2;
  logic [31:0] item_count;
  modport source (output valid, req_type, key_word0, key_word1, key_word2, item_count,
                  input ready);
  modport sink   (input valid, req_type, key_word0, key_word1, key_word2, item_count,
                  output ready);
endinterface

interface chaf_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] pass_count;
  modport source (output valid, status, pass_count, input ready);
  modport sink   (input valid, status, pass_count, output ready);
endinterface

interface chaf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_words;
  modport source (output valid, key_words, input ready);
  modport sink   (input valid, key_words, output ready);
endinterface
`default_nettype wire

/* design/cuckoo_hash_anti_join_filter.sv */
// Flow: the active key words (k = 1..3) are hashed, the first slot and then the second
//   slot are read and compared; a build miss then inserts with displacement kicks.
// Inserts make up to TABLE_HALF displacement kicks; past that the last displaced entry is dropped.
// Items are handled one at a time: a new request is taken only after the response is loaded.
// Reset: synchronous; a clearing pass over all 2*TABLE_HALF slots follows, during which
//   no request is taken (configuration writes still are). key_words resets to 1.
// ----------------------------------------------------------------------------
// Cuckoo hash anti-join filter
// Two-way cuckoo table in one RAM: build aggregates, inserts or drops; probe filters or passes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cuckoo_hash_anti_join_filter_defines.svh"
module cuckoo_hash_anti_join_filter #(
  parameter int TABLE_HALF = chaf_pkg::TABLE_HALF_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  chaf_req_if.sink   req,
  chaf_rsp_if.source rsp,
  chaf_cfg_if.sink   cfg
);
  localparam int DEPTH = 2 * TABLE_HALF;
  localparam int SW    = $clog2(DEPTH);
  localparam int NW    = $clog2(TABLE_HALF);
  localparam int EW    = $bits(chaf_pkg::entry_t);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_CMP1  = 7'b0001000,
    S_CMP2  = 7'b0010000,
    S_KCHK  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t              state;
  logic                kicking;
  logic [SW-1:0]       clr_addr;
  logic [1:0]          cfg_kw;
  logic [1:0]          kw;
  logic                probe;
  logic [2:0][31:0]    hand_w;
  logic [31:0]         hand_cnt;
  logic                first;
  logic [NW-1:0]       kick_n;
  chaf_pkg::status_t   res_status;
  logic [31:0]         res_pass;

  chaf_pkg::hash_req_t hreq;
  logic                hdone;
  logic [SW-1:0]       slot1, slot2, kslot;
  logic                we, re;
  logic [SW-1:0]       waddr, raddr;
  chaf_pkg::entry_t    wdata, rd;
  logic [EW-1:0]       rd_bits;
  logic                match;
  logic [32:0]         sum;
  logic [31:0]         agg_cnt;
  logic [1:0]          k_eff;

  // Key length 0 acts as 1; the cap is 3 words.
  always_comb begin
    k_eff = cfg_kw;
    if (k_eff == 2'd0) k_eff = 2'd1;
    if (32'(k_eff) > chaf_pkg::KEY_CAP) k_eff = 2'(chaf_pkg::KEY_CAP);
  end

  chaf_hash #(.TABLE_HALF(TABLE_HALF)) u_hash (
    .clk(clk), .rst(rst), .req(hreq), .words(hand_w),
    .done(hdone), .slot1(slot1), .slot2(slot2)
  );

  chaf_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rd_bits)
  );

  assign rd    = chaf_pkg::entry_t'(rd_bits);
  assign kslot = first ? slot1 : slot2;
  assign match = rd.valid && (rd.w0 == hand_w[0]) &&
                 (kw < 2'd2 || rd.w1 == hand_w[1]) &&
                 (kw < 2'd3 || rd.w2 == hand_w[2]);
  assign sum     = {1'b0, rd.cnt} + {1'b0, hand_cnt};
  assign agg_cnt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    hreq.start  = 1'b0;
    hreq.nwords = kw;
    we    = 1'b0;
    waddr = kslot;
    wdata = '{valid: 1'b1, w2: hand_w[2], w1: hand_w[1], w0: hand_w[0], cnt: hand_cnt};
    re    = 1'b0;
    raddr = slot1;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      S_IDLE: begin
        hreq.start  = req.valid;
        hreq.nwords = k_eff;
      end
      S_HASH: begin
        re    = hdone;
        raddr = kicking ? kslot : slot1;
      end
      S_CMP1: begin
        if (match) begin
          we = !probe;
          waddr = slot1;
          wdata = '{valid: 1'b1, w2: rd.w2, w1: rd.w1, w0: rd.w0, cnt: agg_cnt};
        end else begin
          re    = 1'b1;
          raddr = slot2;
        end
      end
      S_CMP2: begin
        if (match) begin
          we = !probe;
          waddr = slot2;
          wdata = '{valid: 1'b1, w2: rd.w2, w1: rd.w1, w0: rd.w0, cnt: agg_cnt};
        end else if (!probe) begin
          re    = 1'b1;
          raddr = slot1;
        end
      end
      S_KCHK: begin
        we         = 1'b1;
        hreq.start = rd.valid && (kick_n != NW'(TABLE_HALF - 1));
      end
      S_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      cfg_kw    <= 2'd1;
      rsp.valid <= 1'b0;
      kicking   <= 1'b0;
    end else begin
      if (cfg.valid) cfg_kw <= cfg.key_words;
      // In the response state a completed transfer is followed by the next load.
      if (rsp.valid && rsp.ready && state != S_RESP) rsp.valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + SW'(1);
          if (clr_addr == SW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            kw        <= k_eff;
            probe     <= req.req_type;
            hand_cnt  <= req.item_count;
            hand_w[0] <= req.key_word0;
            hand_w[1] <= (k_eff >= 2'd2) ? req.key_word1 : 32'd0;
            hand_w[2] <= (k_eff >= 2'd3) ? req.key_word2 : 32'd0;
            kicking   <= 1'b0;
            state     <= S_HASH;
          end
        end
        S_HASH: begin
          if (hdone) state <= kicking ? S_KCHK : S_CMP1;
        end
        S_CMP1, S_CMP2: begin
          if (match) begin
            res_status <= probe ? chaf_pkg::ST_FILTERED : chaf_pkg::ST_AGGREGATED;
            res_pass   <= '0;
            state      <= S_RESP;
          end else if (state == S_CMP1) begin
            state <= S_CMP2;
          end else if (probe) begin
            res_status <= chaf_pkg::ST_PASS;
            res_pass   <= hand_cnt;
            state      <= S_RESP;
          end else begin
            res_pass <= '0;
            kicking  <= 1'b1;
            first    <= 1'b1;
            kick_n   <= '0;
            state    <= S_KCHK;
          end
        end
        S_KCHK: begin
          if (!rd.valid) begin
            res_status <= chaf_pkg::ST_INSERTED;
            state      <= S_RESP;
          end else begin
            // The displaced entry becomes the one in hand.
            hand_w[0] <= rd.w0;
            hand_w[1] <= rd.w1;
            hand_w[2] <= rd.w2;
            hand_cnt  <= rd.cnt;
            first     <= !first;
            kick_n    <= kick_n + NW'(1);
            if (kick_n == NW'(TABLE_HALF - 1)) begin
              res_status <= chaf_pkg::ST_DROPPED;
              state      <= S_RESP;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_RESP: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.status     <= res_status;
            rsp.pass_count <= res_pass;
            state          <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  `CHAF_ASSERT_IMP(a_no_req_in_clear, state == S_CLEAR, !req.ready, "request taken during clear")
  `CHAF_ASSERT_IMP(a_hash_done_in_hash, hdone, state == S_HASH, "hash finished outside hash wait")
  `CHAF_ASSERT_IMP(a_store_valid, we && state != S_CLEAR, wdata.valid, "slot stored without valid")
  `CHAF_ASSERT_NXT(a_rsp_from_resp, state == S_RESP && (!rsp.valid || rsp.ready),
                   rsp.valid && state == S_IDLE, "response not loaded")
endmodule
`default_nettype wire

/* design/chaf_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module chaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/chaf_hash.sv */
// ----------------------------------------------------------------------------
// Cuckoo slot hash unit
// Folds one key word per cycle into the shift-add and multiplicative hashes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module chaf_hash #(
  parameter int TABLE_HALF = chaf_pkg::TABLE_HALF_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire chaf_pkg::hash_req_t             req,
  input  wire logic [2:0][31:0]                words,
  output logic                                 done,
  output logic [$clog2(2*TABLE_HALF)-1:0]      slot1,
  output logic [$clog2(2*TABLE_HALF)-1:0]      slot2
);
  localparam int SW = $clog2(2*TABLE_HALF);
  localparam logic [31:0] MASK = 32'(TABLE_HALF - 1);
  localparam logic [31:0] HALF = 32'(TABLE_HALF);

  logic        busy;
  logic [1:0]  idx;
  logic [1:0]  nwords;
  logic [31:0] h1, h2;
  logic [31:0] w, mix, prod, s1_full, s2_full;

  assign w    = words[idx];
  assign mix  = w ^ (w >> 3);
  assign prod = h2 * mix;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        idx    <= '0;
        nwords <= req.nwords;
        h1     <= '0;
        h2     <= 32'd1;
      end else if (busy) begin
        h1  <= (h1 << 1) + w;
        h2  <= prod;
        idx <= idx + 2'd1;
        if (idx == nwords - 2'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign s1_full = h1 & MASK;
  assign s2_full = HALF + ((h2 ^ (h2 >> 3)) & MASK);
  assign slot1   = s1_full[SW-1:0];
  assign slot2   = s2_full[SW-1:0];
endmodule
`default_nettype wire

/* tb/sv/tb_cuckoo_hash_anti_join_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cuckoo hash anti-join filter testbench
// Drives build and probe transfers under several key lengths and predicts
// each status and pass count from a local copy of the two-way cuckoo table.
// Colliding key groups force kick-limit drops when one key word is active. Both sides idle at random,
// and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_cuckoo_hash_anti_join_filter;

  localparam int HALF = chaf_pkg::TABLE_HALF_DEF;
  localparam int POOL = 64;

  typedef bit [2:0][31:0] key_t;

  class filter_scoreboard;
    bit                slot_used[2*HALF];
    key_t              slot_key[2*HALF];
    bit [31:0]         slot_cnt[2*HALF];
    int unsigned       nwords;
    chaf_pkg::status_t exp_status[$];
    bit [31:0]         exp_count[$];
    int                errors;

    function new();
      nwords = 1;
      errors = 0;
      foreach (slot_used[i]) slot_used[i] = 0;
    endfunction

    function void set_key_words(bit [1:0] v);
      nwords = (v == 2'd0) ? 1 : v;
      if (nwords > chaf_pkg::KEY_CAP) nwords = chaf_pkg::KEY_CAP;
    endfunction

    function int unsigned fold_slot(key_t key);
      bit [31:0] h;
      h = 0;
      for (int i = 0; i < nwords; i++) h = (h << 1) + key[i];
      return h & (HALF - 1);
    endfunction

    function int unsigned mult_slot(key_t key);
      bit [31:0] h;
      h = 1;
      for (int i = 0; i < nwords; i++) h = h * (key[i] ^ (key[i] >> 3));
      return HALF + ((h ^ (h >> 3)) & (HALF - 1));
    endfunction

    function bit holds_key(int unsigned s, key_t key);
      if (!slot_used[s]) return 0;
      for (int i = 0; i < nwords; i++)
        if (slot_key[s][i] != key[i]) return 0;
      return 1;
    endfunction

    // Returns 1 if the entry in hand finally lands in an empty slot.
    function bit cuckoo_place(key_t key, bit [31:0] cnt);
      bit          use_fold;
      int unsigned s;
      key_t        old_key;
      bit [31:0]   old_cnt;
      use_fold = 1;
      for (int n = 0; n < HALF; n++) begin
        s = use_fold ? fold_slot(key) : mult_slot(key);
        if (!slot_used[s]) begin
          slot_used[s] = 1;
          slot_key[s]  = key;
          slot_cnt[s]  = cnt;
          return 1;
        end
        old_key = slot_key[s];
        old_cnt = slot_cnt[s];
        slot_key[s] = key;
        slot_cnt[s] = cnt;
        key = old_key;
        cnt = old_cnt;
        use_fold = !use_fold;
      end
      return 0;
    endfunction

    function void add_result(chaf_pkg::status_t st, bit [31:0] cnt);
      exp_status = {exp_status, st};
      exp_count  = {exp_count, cnt};
    endfunction

    function void note_request(bit probe, key_t key, bit [31:0] cnt);
      int          hit;
      int unsigned s1, s2;
      bit [32:0]   sum;
      for (int i = nwords; i < 3; i++) key[i] = 0;
      s1 = fold_slot(key);
      s2 = mult_slot(key);
      hit = holds_key(s1, key) ? int'(s1) : holds_key(s2, key) ? int'(s2) : -1;
      if (probe) begin
        add_result(hit >= 0 ? chaf_pkg::ST_FILTERED : chaf_pkg::ST_PASS,
                   hit >= 0 ? 32'd0 : cnt);
      end else if (hit >= 0) begin
        sum = slot_cnt[hit] + cnt;
        slot_cnt[hit] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        add_result(chaf_pkg::ST_AGGREGATED, 32'd0);
      end else begin
        add_result(cuckoo_place(key, cnt) ? chaf_pkg::ST_INSERTED : chaf_pkg::ST_DROPPED,
                   32'd0);
      end
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] pc);
      chaf_pkg::status_t es;
      bit [31:0]         ec;
      if (exp_status.size() == 0) begin
        $display("%0t: unexpected result status=%0d pass_count=%h", $time, st, pc);
        errors++;
        return;
      end
      es = exp_status.pop_front();
      ec = exp_count.pop_front();
      if (st !== es) begin
        $display("%0t: status expected %0d actual %0d", $time, es, st);
        errors++;
      end
      if (pc !== ec) begin
        $display("%0t: pass_count expected %h actual %h", $time, ec, pc);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  chaf_req_if req ();
  chaf_rsp_if rsp ();
  chaf_cfg_if cfg ();

  cuckoo_hash_anti_join_filter i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  filter_scoreboard sb;
  int   burst_left;
  bit   long_hold_req;
  int   hold_left;
  int   ready_pct;
  int   stretch_left;
  key_t key_pool[POOL];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready)
      sb.note_request(req.req_type, {req.key_word2, req.key_word1, req.key_word0},
                      req.item_count);
    if (!rst && rsp.valid && rsp.ready) sb.check_result(rsp.status, rsp.pass_count);
  end

  // Receiver stall pattern: stretches of varying ready rate, plus one long hold-off.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 0;
      hold_left = 400;
    end
    if (stretch_left == 0) begin
      case ($urandom_range(3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 40;
        default: ready_pct = 10;
      endcase
      stretch_left = $urandom_range(50, 300);
    end
    stretch_left--;
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) < ready_pct);
    end
  end

  task automatic send_item(bit probe, key_t key, bit [31:0] cnt);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk);
        req.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    req.valid      <= 1'b1;
    req.req_type   <= probe;
    req.key_word0  <= key[0];
    req.key_word1  <= key[1];
    req.key_word2  <= key[2];
    req.item_count <= cnt;
    do @(posedge clk); while (!(req.valid && req.ready));
    burst_left--;
  endtask

  // Drains every expected result, then writes key_words.
  task automatic write_key_words(bit [1:0] v);
    @(negedge clk);
    req.valid <= 1'b0;
    while (sb.exp_status.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
    cfg.valid     <= 1'b1;
    cfg.key_words <= v;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    sb.set_key_words(v);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic bit [31:0] pick_count();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom();
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  // Under a one-word key, keys differing only above bit 19 of word 0 share both slots.
  task automatic send_collision_group(bit [31:0] base);
    for (int i = 0; i < 3; i++)
      send_item(1'b0, {$urandom(), $urandom(), base ^ ($urandom_range(1, 4095) << 20)},
                pick_count());
  endtask

  task automatic send_random_item();
    int   sel;
    int   idx;
    key_t key;
    sel = $urandom_range(99);
    idx = $urandom_range(POOL - 1);
    if ($urandom_range(19) == 0) key_pool[idx] = {$urandom(), $urandom(), $urandom()};
    key = key_pool[idx];
    // Scramble word 2, and word 1 for one-word keys; words past the active length must not matter.
    if ($urandom_range(3) == 0) begin
      key[2] = $urandom();
      if (sb.nwords == 1) key[1] = $urandom();
    end
    if (sel < 45) send_item(1'b0, key, pick_count());
    else if (sel < 80) send_item(1'b1, key, pick_count());
    else if (sel < 90) send_item(1'b0, {$urandom(), $urandom(), $urandom()}, pick_count());
    else send_item(1'b1, {$urandom(), $urandom(), $urandom()}, pick_count());
  endtask

  initial begin
    sb = new();
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.req_type   = 1'b0;
    req.key_word0  = '0;
    req.key_word1  = '0;
    req.key_word2  = '0;
    req.item_count = '0;
    rsp.ready      = 1'b0;
    cfg.valid      = 1'b0;
    cfg.key_words  = 2'd1;
    burst_left     = 0;
    long_hold_req  = 0;
    hold_left      = 0;
    ready_pct      = 100;
    stretch_left   = 0;
    foreach (key_pool[i]) key_pool[i] = {$urandom(), $urandom(), $urandom()};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, one word of key and then three.
    send_item(1'b0, {32'd0, 32'd0, 32'd0}, 32'd0);
    send_item(1'b0, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 32'hFFFF_FFFF);
    send_item(1'b0, {32'd0, 32'd0, 32'hFFFF_FFFF}, 32'd1);
    send_item(1'b0, {32'h1234_5678, 32'h9ABC_DEF0, 32'd0}, 32'd5);
    send_item(1'b1, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0}, 32'd7);
    send_item(1'b1, {32'd0, 32'd0, 32'd5}, 32'hFFFF_FFFF);
    send_item(1'b1, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE}, 32'hFFFF_FFFF);
    send_item(1'b1, {32'd0, 32'd0, 32'd6}, 32'd0);
    send_collision_group(32'h0003_2A5C);
    send_item(1'b1, {32'd0, 32'd0, 32'h0003_2A5C}, 32'd9);
    send_item(1'b0, {32'd0, 32'd0, 32'h0003_2A5C}, 32'd9);
    send_item(1'b1, {32'd0, 32'd0, 32'h0003_2A5C}, 32'd9);
    write_key_words(2'd3);
    send_item(1'b0, {32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF}, 32'h8000_0000);
    send_item(1'b0, {32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF}, 32'h8000_0000);
    send_item(1'b1, {32'hA5A5_A5A4, 32'h5A5A_5A5A, 32'hFFFF_FFFF}, 32'd3);
    send_item(1'b1, {32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF}, 32'd3);
    send_collision_group(32'h000F_F001);

    // Random phases over all key lengths; a zero setting behaves as one word.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_key_words(2'd1);
        1: write_key_words(2'd2);
        2: write_key_words(2'd0);
        3: write_key_words(2'd3);
        default: write_key_words(2'd2);
      endcase
      for (int n = 0; n < 345; n++) begin
        if (ph == 1 && n == 150) long_hold_req = 1;
        if ($urandom_range(99) == 0) send_collision_group($urandom());
        else send_random_item();
      end
    end

    @(negedge clk);
    req.valid <= 1'b0;
    while (sb.exp_status.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
